// ===== design/s5hs_pkg.sv =====
package s5hs_pkg;

    localparam int TIMER_BITS_DEF = 16;

    localparam logic [7:0] SOCKS_VER  = 8'h05;
    localparam logic [7:0] AUTH_VER   = 8'h01;
    localparam logic [7:0] AUTH_OK    = 8'h00;
    localparam logic [7:0] M_NOAUTH   = 8'h00;
    localparam logic [7:0] M_USERPASS = 8'h02;
    localparam logic [7:0] AT_IPV4    = 8'h01;
    localparam logic [7:0] AT_NAME    = 8'h03;
    localparam logic [7:0] AT_IPV6    = 8'h04;
    localparam logic [7:0] RSV_ZERO   = 8'h00;
    localparam logic [7:0] V4_BYTES   = 8'd4;
    localparam logic [7:0] V6_BYTES   = 8'd16;
    localparam logic [7:0] PORT_BYTES = 8'd2;

    localparam int CFG_DATA_W = 16;

    typedef enum logic [0:0] {
        CFG_USE_AUTH     = 1'b0,
        CFG_RECV_TIMEOUT = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        REQ_START  = 3'd0,
        REQ_BYTE   = 3'd1,
        REQ_TICK   = 3'd2,
        REQ_DISC   = 3'd3,
        REQ_INTR   = 3'd4,
        REQ_NETERR = 3'd5
    } t_req;

    typedef enum logic [2:0] {
        ACT_GREETING = 3'd0,
        ACT_AUTH     = 3'd1,
        ACT_CONNECT  = 3'd2,
        ACT_SUCCESS  = 3'd3,
        ACT_FAIL     = 3'd4
    } t_action;

    typedef enum logic [3:0] {
        FAIL_NONE       = 4'd0,
        FAIL_INIT_VER   = 4'd1,
        FAIL_AUTH_REJ   = 4'd2,
        FAIL_METHOD     = 4'd3,
        FAIL_REPLY_VER  = 4'd4,
        FAIL_REFUSED    = 4'd5,
        FAIL_RESERVED   = 4'd6,
        FAIL_ADDR_TYPE  = 4'd7,
        FAIL_TIMEOUT    = 4'd8,
        FAIL_DISC       = 4'd9,
        FAIL_INTR       = 4'd10,
        FAIL_NETERR     = 4'd11
    } t_fail;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_METHOD = 4'd1,
        PH_AUTH   = 4'd2,
        PH_REPLY  = 4'd3,
        PH_V4     = 4'd4,
        PH_V6     = 4'd5,
        PH_NLEN   = 4'd6,
        PH_NAME   = 4'd7,
        PH_PORT   = 4'd8
    } t_phase;

    typedef struct packed {
        t_action    action;
        t_fail      fail_code;
        logic [7:0] proxy_reply;
    } t_word;

    typedef struct packed {
        logic  vld;
        t_word word;
    } t_result;

endpackage

// ===== design/s5hs_core.sv =====
module s5hs_core #(
    parameter int TIMER_BITS = s5hs_pkg::TIMER_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [2:0]          i_req_type,
    input  logic [7:0]          i_rx_byte,
    input  logic                i_use_auth,
    input  logic [15:0]         i_recv_timeout,
    output s5hs_pkg::t_result   o_result
);

    localparam int CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;

    s5hs_pkg::t_phase        r_phase;
    s5hs_pkg::t_phase        n_phase;
    logic [7:0]              r_idx;
    logic [7:0]              n_idx;
    logic [7:0]              r_nlen;
    logic [7:0]              n_nlen;
    logic [7:0]              r_held;
    logic [7:0]              n_held;
    logic [TIMER_BITS-1:0]   r_timer;
    logic [TIMER_BITS-1:0]   n_timer;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= s5hs_pkg::PH_IDLE;
            r_idx   <= 8'd0;
            r_nlen  <= 8'd0;
            r_held  <= 8'd0;
            r_timer <= '0;
        end else begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_nlen  <= n_nlen;
            r_held  <= n_held;
            r_timer <= n_timer;
        end
    end

    always_comb begin
        s5hs_pkg::t_req   req;
        s5hs_pkg::t_phase enter_ph;
        s5hs_pkg::t_fail  fail_c;
        logic             do_enter;
        logic             do_fail;
        logic             busy;
        logic [7:0]       idx_inc;
        logic [7:0]       fail_rep;
        logic [7:0]       b;

        req      = s5hs_pkg::t_req'(i_req_type);
        b        = i_rx_byte;
        enter_ph = s5hs_pkg::PH_IDLE;
        fail_c   = s5hs_pkg::FAIL_NONE;
        do_enter = 1'b0;
        do_fail  = 1'b0;
        fail_rep = 8'h00;
        idx_inc  = r_idx + 8'd1;
        busy     = (r_phase >= s5hs_pkg::PH_METHOD) && (r_phase <= s5hs_pkg::PH_PORT);

        n_phase  = r_phase;
        n_idx    = r_idx;
        n_nlen   = r_nlen;
        n_held   = r_held;
        n_timer  = r_timer;

        o_result.vld              = 1'b0;
        o_result.word.action      = s5hs_pkg::ACT_GREETING;
        o_result.word.fail_code   = s5hs_pkg::FAIL_NONE;
        o_result.word.proxy_reply = 8'h00;

        if (i_accept) begin
            if (req == s5hs_pkg::REQ_START) begin
                do_enter             = 1'b1;
                enter_ph             = s5hs_pkg::PH_METHOD;
                n_nlen               = 8'd0;
                n_held               = 8'd0;
                o_result.vld         = 1'b1;
                o_result.word.action = s5hs_pkg::ACT_GREETING;
            end else if (!busy) begin
                if (r_phase != s5hs_pkg::PH_IDLE) begin
                    do_enter = 1'b1;
                    enter_ph = s5hs_pkg::PH_IDLE;
                end
            end else begin
                case (req)
                    s5hs_pkg::REQ_BYTE: begin
                        n_idx = idx_inc;
                        case (r_phase)
                            s5hs_pkg::PH_METHOD: begin
                                if (r_idx == 8'd0) begin
                                    n_held = b;
                                end else if (r_held != s5hs_pkg::SOCKS_VER) begin
                                    do_fail = 1'b1;
                                    fail_c  = s5hs_pkg::FAIL_INIT_VER;
                                end else if (b == s5hs_pkg::M_USERPASS && i_use_auth) begin
                                    do_enter             = 1'b1;
                                    enter_ph             = s5hs_pkg::PH_AUTH;
                                    o_result.vld         = 1'b1;
                                    o_result.word.action = s5hs_pkg::ACT_AUTH;
                                end else if (b == s5hs_pkg::M_NOAUTH) begin
                                    do_enter             = 1'b1;
                                    enter_ph             = s5hs_pkg::PH_REPLY;
                                    o_result.vld         = 1'b1;
                                    o_result.word.action = s5hs_pkg::ACT_CONNECT;
                                end else begin
                                    do_fail = 1'b1;
                                    fail_c  = s5hs_pkg::FAIL_METHOD;
                                end
                            end
                            s5hs_pkg::PH_AUTH: begin
                                if (r_idx == 8'd0) begin
                                    n_held = b;
                                end else if (r_held != s5hs_pkg::AUTH_VER
                                             || b != s5hs_pkg::AUTH_OK) begin
                                    do_fail = 1'b1;
                                    fail_c  = s5hs_pkg::FAIL_AUTH_REJ;
                                end else begin
                                    do_enter             = 1'b1;
                                    enter_ph             = s5hs_pkg::PH_REPLY;
                                    o_result.vld         = 1'b1;
                                    o_result.word.action = s5hs_pkg::ACT_CONNECT;
                                end
                            end
                            s5hs_pkg::PH_REPLY: begin
                                if (r_idx == 8'd0) begin
                                    n_nlen = (b != s5hs_pkg::SOCKS_VER)
                                           ? {4'd0, s5hs_pkg::FAIL_REPLY_VER} : 8'd0;
                                end else if (r_idx == 8'd1) begin
                                    n_held = b;
                                    if (r_nlen == 8'd0 && b != 8'd0) begin
                                        n_nlen = {4'd0, s5hs_pkg::FAIL_REFUSED};
                                    end
                                end else if (r_idx == 8'd2) begin
                                    if (r_nlen == 8'd0 && b != s5hs_pkg::RSV_ZERO) begin
                                        n_nlen = {4'd0, s5hs_pkg::FAIL_RESERVED};
                                    end
                                end else if (r_nlen != 8'd0) begin
                                    do_fail  = 1'b1;
                                    fail_c   = s5hs_pkg::t_fail'(r_nlen[3:0]);
                                    fail_rep = r_held;
                                end else if (b == s5hs_pkg::AT_IPV4) begin
                                    do_enter = 1'b1;
                                    enter_ph = s5hs_pkg::PH_V4;
                                end else if (b == s5hs_pkg::AT_IPV6) begin
                                    do_enter = 1'b1;
                                    enter_ph = s5hs_pkg::PH_V6;
                                end else if (b == s5hs_pkg::AT_NAME) begin
                                    do_enter = 1'b1;
                                    enter_ph = s5hs_pkg::PH_NLEN;
                                end else begin
                                    do_fail = 1'b1;
                                    fail_c  = s5hs_pkg::FAIL_ADDR_TYPE;
                                end
                            end
                            s5hs_pkg::PH_V4: begin
                                if (idx_inc >= s5hs_pkg::V4_BYTES) begin
                                    do_enter = 1'b1;
                                    enter_ph = s5hs_pkg::PH_PORT;
                                end
                            end
                            s5hs_pkg::PH_V6: begin
                                if (idx_inc >= s5hs_pkg::V6_BYTES) begin
                                    do_enter = 1'b1;
                                    enter_ph = s5hs_pkg::PH_PORT;
                                end
                            end
                            s5hs_pkg::PH_NLEN: begin
                                n_nlen   = b;
                                do_enter = 1'b1;
                                enter_ph = (b == 8'd0) ? s5hs_pkg::PH_PORT
                                                       : s5hs_pkg::PH_NAME;
                            end
                            s5hs_pkg::PH_NAME: begin
                                if (idx_inc >= r_nlen) begin
                                    do_enter = 1'b1;
                                    enter_ph = s5hs_pkg::PH_PORT;
                                end
                            end
                            s5hs_pkg::PH_PORT: begin
                                if (idx_inc >= s5hs_pkg::PORT_BYTES) begin
                                    do_enter             = 1'b1;
                                    enter_ph             = s5hs_pkg::PH_IDLE;
                                    o_result.vld         = 1'b1;
                                    o_result.word.action = s5hs_pkg::ACT_SUCCESS;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                    s5hs_pkg::REQ_TICK: begin
                        if (!(&r_timer)) begin
                            n_timer = r_timer + {{(TIMER_BITS-1){1'b0}}, 1'b1};
                        end
                        if (CMP_W'(n_timer) >= CMP_W'(i_recv_timeout)) begin
                            do_fail = 1'b1;
                            fail_c  = s5hs_pkg::FAIL_TIMEOUT;
                        end
                    end
                    s5hs_pkg::REQ_DISC: begin
                        do_fail = 1'b1;
                        fail_c  = s5hs_pkg::FAIL_DISC;
                    end
                    s5hs_pkg::REQ_INTR: begin
                        do_fail = 1'b1;
                        fail_c  = s5hs_pkg::FAIL_INTR;
                    end
                    s5hs_pkg::REQ_NETERR: begin
                        do_fail = 1'b1;
                        fail_c  = s5hs_pkg::FAIL_NETERR;
                    end
                    default: begin
                    end
                endcase
            end
        end

        if (do_fail) begin
            do_enter                  = 1'b1;
            enter_ph                  = s5hs_pkg::PH_IDLE;
            o_result.vld              = 1'b1;
            o_result.word.action      = s5hs_pkg::ACT_FAIL;
            o_result.word.fail_code   = fail_c;
            o_result.word.proxy_reply = (fail_c == s5hs_pkg::FAIL_REFUSED) ? fail_rep : 8'h00;
        end

        if (do_enter) begin
            n_phase = enter_ph;
            n_idx   = 8'd0;
            n_timer = '0;
        end
    end

endmodule

// ===== design/s5hs_obuf.sv =====
module s5hs_obuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  s5hs_pkg::t_result i_push,
    input  logic              i_stall,
    output logic              o_full,
    output logic              o_valid,
    output s5hs_pkg::t_word   o_word
);

    logic            r_main_vld;
    logic            n_main_vld;
    logic            r_skid_vld;
    logic            n_skid_vld;
    s5hs_pkg::t_word r_main;
    s5hs_pkg::t_word n_main;
    s5hs_pkg::t_word r_skid;
    s5hs_pkg::t_word n_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_vld <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_main_vld <= n_main_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_main <= n_main;
        r_skid <= n_skid;
    end

    always_comb begin
        logic take;

        take       = r_main_vld & ~i_stall;
        n_main     = r_main;
        n_skid     = r_skid;
        n_main_vld = r_main_vld & ~take;
        n_skid_vld = r_skid_vld;

        if (r_skid_vld) begin
            if (take) begin
                n_main     = r_skid;
                n_main_vld = 1'b1;
                n_skid_vld = 1'b0;
            end
        end else if (i_push.vld) begin
            if (!r_main_vld || take) begin
                n_main     = i_push.word;
                n_main_vld = 1'b1;
            end else begin
                n_skid     = i_push.word;
                n_skid_vld = 1'b1;
            end
        end
    end

    assign o_full  = r_skid_vld;
    assign o_valid = r_main_vld;
    assign o_word  = r_main;

endmodule

// ===== design/socks5_client_handshake_top.sv =====
// Client-side SOCKS5 handshake sequencer.
// Input channel (i_in_valid / o_in_stall) carries one event word per unstalled cycle:
// start, a received proxy byte, a millisecond tick, or an abort event.
// Output channel (o_out_valid / i_out_stall) carries the action words: send
// greeting, send auth request, send connect request, success, or failure
// with its code and, for a refused connect, the proxy reply byte.
// An event word is judged in the cycle it is accepted and its result, if
// any, is registered in the output buffer before it appears on the output.
// One event word is accepted every cycle while o_in_stall is low.
// A two-entry output buffer lets input keep flowing while the receiver holds
// one result; o_in_stall rises only when both entries are occupied and
// falls as soon as the receiver takes a word.
// Reset puts the sequencer in the idle phase, empties the output buffer and
// loads use_auth = 0 and recv_timeout = 20000 ticks.
// Configuration writes take effect at the next clock edge; write only while
// no handshake result is outstanding.
module socks5_client_handshake_top #(
    parameter int TIMER_BITS = s5hs_pkg::TIMER_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [2:0]                      i_req_type,
    input  logic [7:0]                      i_rx_byte,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [2:0]                      o_action,
    output logic [3:0]                      o_fail_code,
    output logic [7:0]                      o_proxy_reply,
    input  logic                            i_cfg_we,
    input  logic [0:0]                      i_cfg_idx,
    input  logic [s5hs_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic              r_use_auth;
    logic [15:0]       r_recv_timeout;
    logic              accept;
    logic              full;
    s5hs_pkg::t_result result;
    s5hs_pkg::t_word   word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_auth     <= 1'b0;
            r_recv_timeout <= 16'd20000;
        end else if (i_cfg_we) begin
            case (s5hs_pkg::t_cfg_idx'(i_cfg_idx))
                s5hs_pkg::CFG_USE_AUTH:     r_use_auth     <= i_cfg_data[0];
                s5hs_pkg::CFG_RECV_TIMEOUT: r_recv_timeout <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    assign accept     = i_in_valid & ~full;
    assign o_in_stall = full;

    s5hs_core #(
        .TIMER_BITS(TIMER_BITS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_req_type     (i_req_type),
        .i_rx_byte      (i_rx_byte),
        .i_use_auth     (r_use_auth),
        .i_recv_timeout (r_recv_timeout),
        .o_result       (result)
    );

    s5hs_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (result),
        .i_stall (i_out_stall),
        .o_full  (full),
        .o_valid (o_out_valid),
        .o_word  (word)
    );

    assign o_action      = word.action;
    assign o_fail_code   = word.fail_code;
    assign o_proxy_reply = word.proxy_reply;

endmodule

// ===== design/s5hs_chk.sv =====
module s5hs_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [2:0] o_action,
    input logic [3:0] o_fail_code,
    input logic [7:0] o_proxy_reply
);

    a_held_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_action)
            && $stable(o_fail_code) && $stable(o_proxy_reply))
        else $error("Stalled output word changed.");

    a_fail_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_action == s5hs_pkg::ACT_FAIL)
            == (o_fail_code != s5hs_pkg::FAIL_NONE)))
        else $error("Failure code does not match the action.");

    a_reply_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_fail_code != s5hs_pkg::FAIL_REFUSED |-> o_proxy_reply == 8'd0)
        else $error("Proxy reply byte set without a refusal.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("Output buffer not empty after reset.");

endmodule

bind socks5_client_handshake_top s5hs_chk u_s5hs_chk (.*);
